// ===== design/dla_particle_walk_unit_macros.svh =====
// Assertion macros shared by the particle walk unit modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef DLA_PARTICLE_WALK_UNIT_MACROS_SVH
`define DLA_PARTICLE_WALK_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DPW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define DPW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dpw_pkg.sv =====
// Shared types and constants for the particle walk unit.
// No dependencies; imported by the controller, datapath and top level.
package dpw_pkg;

   localparam int OP_W        = 1;
   localparam int START_X_W   = 10;
   localparam int START_Y_W   = 9;
   localparam int STEP_W      = 2;
   localparam int POS_X_W     = 10;
   localparam int POS_Y_W     = 9;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 16;

   // request word layout
   localparam int REQ_SX_LO   = 0;
   localparam int REQ_SY_LO   = REQ_SX_LO + START_X_W;
   localparam int REQ_STX_LO  = REQ_SY_LO + START_Y_W;
   localparam int REQ_STY_LO  = REQ_STX_LO + STEP_W;
   localparam int REQ_BITS    = REQ_STY_LO + STEP_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;

   // response word layout
   localparam int RSP_PX_LO   = 0;
   localparam int RSP_PY_LO   = RSP_PX_LO + POS_X_W;
   localparam int RSP_REM_LO  = RSP_PY_LO + POS_Y_W;
   localparam int RSP_DONE_LO = RSP_REM_LO + COUNT_W;
   localparam int RSP_BITS    = RSP_DONE_LO + 1;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd20000;

   localparam logic [STEP_W-1:0] STEP_ZERO = 2'b00;
   localparam logic [STEP_W-1:0] STEP_INC  = 2'b01;

   typedef enum logic [OP_W-1:0] {
      OP_LAUNCH = 1'b0,
      OP_MOVE   = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_WALKING = 2'd0,
      ST_STUCK   = 2'd1,
      ST_LOST    = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ROW_ABOVE = 2'd0,
      ROW_SAME  = 2'd1,
      ROW_BELOW = 2'd2
   } row_sel_type;

   typedef struct packed {
      logic        accept;
      logic        rd_en;
      row_sel_type rd_sel;
      logic        clr_en;
      logic        commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic go_walk;
      logic out_free;
   } dp_status_type;

endpackage

// ===== design/dpw_grid_mem.sv =====
// Row-wide occupancy grid storage, one row per address.
// No dependencies; used by the datapath.
module dpw_grid_mem #(
   parameter int ROW_BITS = 640,
   parameter int ROWS     = 480,
   localparam int AW      = $clog2(ROWS)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [ROW_BITS-1:0] wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic [ROW_BITS-1:0] rd_data
);

   logic [ROW_BITS-1:0] mem [ROWS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== design/dpw_ctrl.sv =====
// Sequencer for the particle walk unit: clear pass, item intake, row reads, commit.
// Depends on dpw_pkg and dla_particle_walk_unit_macros.svh.
`include "dla_particle_walk_unit_macros.svh"

module dpw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  dpw_pkg::dp_status_type status,
   output dpw_pkg::ctrl_cmd_type  cmd
);
   import dpw_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECIDE,
      S_READ_SAME,
      S_READ_BELOW,
      S_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.go_walk) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ROW_ABOVE;
               state_in   = S_READ_SAME;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_READ_SAME: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ROW_SAME;
            state_in   = S_READ_BELOW;
         end
         S_READ_BELOW: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ROW_BELOW;
            state_in   = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `DPW_ASSERT_NOW(a_commit_free, clock, reset, cmd.commit, status.out_free, "commit over held result")
   `DPW_ASSERT_NOW(a_rd_not_clr, clock, reset, cmd.rd_en, !cmd.clr_en, "row read during clear")
   `DPW_ASSERT_NEXT(a_rd_seq, clock, reset, cmd.rd_en && cmd.rd_sel == ROW_ABOVE, cmd.rd_en && cmd.rd_sel == ROW_SAME, "row reads not back to back")

endmodule

// ===== design/dpw_datapath.sv =====
// Walker position, neighbour test, particle counter, grid access and result register.
// Depends on dpw_pkg, dpw_grid_mem and dla_particle_walk_unit_macros.svh.
`include "dla_particle_walk_unit_macros.svh"

module dpw_datapath #(
   parameter int GRID_WIDTH  = 640,
   parameter int GRID_HEIGHT = 480
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dpw_pkg::ctrl_cmd_type                 cmd,
   output dpw_pkg::dp_status_type                status,
   input  logic [dpw_pkg::OP_W-1:0]              req_operation,
   input  logic [dpw_pkg::START_X_W-1:0]         req_start_x,
   input  logic [dpw_pkg::START_Y_W-1:0]         req_start_y,
   input  logic signed [dpw_pkg::STEP_W-1:0]     req_step_x,
   input  logic signed [dpw_pkg::STEP_W-1:0]     req_step_y,
   input  logic                                  csr_we,
   input  logic [dpw_pkg::COUNT_W-1:0]           csr_data,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [dpw_pkg::POS_X_W-1:0]           rsp_pos_x,
   output logic [dpw_pkg::POS_Y_W-1:0]           rsp_pos_y,
   output dpw_pkg::status_type                   rsp_status,
   output logic [dpw_pkg::COUNT_W-1:0]           rsp_remaining,
   output logic                                  rsp_done
);
   import dpw_pkg::*;

   localparam int XW     = ($clog2(GRID_WIDTH) > POS_X_W) ? $clog2(GRID_WIDTH) : POS_X_W;
   localparam int YW     = ($clog2(GRID_HEIGHT) > POS_Y_W) ? $clog2(GRID_HEIGHT) : POS_Y_W;
   localparam int COL_AW = $clog2(GRID_WIDTH);
   localparam int ROW_AW = $clog2(GRID_HEIGHT);
   localparam logic [XW-1:0]         X_MAX      = XW'(GRID_WIDTH - 1);
   localparam logic [YW-1:0]         Y_MAX      = YW'(GRID_HEIGHT - 1);
   localparam logic [ROW_AW-1:0]     ROW_LAST   = ROW_AW'(GRID_HEIGHT - 1);
   localparam logic [ROW_AW-1:0]     ROW_CENTRE = ROW_AW'(GRID_HEIGHT / 2);
   localparam logic [GRID_WIDTH-1:0] CENTRE_BIT = GRID_WIDTH'(1) << (GRID_WIDTH / 2);

   logic [XW-1:0]         walker_x_ff, walker_x_in;
   logic [YW-1:0]         walker_y_ff, walker_y_in;
   logic                  walker_active_ff, walker_active_in;
   logic [COUNT_W-1:0]    left_ff, left_in;
   logic                  placed_ff, placed_in;
   logic [ROW_AW-1:0]     clr_row_ff;
   logic                  cap_en_ff;
   row_sel_type           cap_sel_ff;
   logic [2:0]            nb_above_ff, nb_below_ff;
   logic [GRID_WIDTH-1:0] mid_row_ff;
   logic                  rsp_valid_ff;
   logic [POS_X_W-1:0]    rsp_x_ff;
   logic [POS_Y_W-1:0]    rsp_y_ff;
   status_type            rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_left_ff;
   logic                  rsp_done_ff;

   logic [XW-1:0]         launch_x, step_x_pos, xm1, xp1, sx_ext;
   logic [YW-1:0]         launch_y, step_y_pos, ym1, yp1, sy_ext, rd_row;
   logic [COL_AW-1:0]     col_m1, col_c, col_p1;
   logic                  on_edge, touch, stuck;
   status_type            result;
   logic [STEP_W-1:0]     step_x_bits, step_y_bits;

   logic                  mem_we, mem_re;
   logic [ROW_AW-1:0]     mem_waddr, mem_raddr;
   logic [GRID_WIDTH-1:0] mem_wdata, mem_rdata;

   // launch position, saturated onto the last column / row
   assign sx_ext   = XW'(req_start_x);
   assign sy_ext   = YW'(req_start_y);
   assign launch_x = (sx_ext > X_MAX) ? X_MAX : sx_ext;
   assign launch_y = (sy_ext > Y_MAX) ? Y_MAX : sy_ext;

   // step codes: +1, 0, anything negative counts as -1
   assign step_x_bits = req_step_x;
   assign step_y_bits = req_step_y;

   always_comb begin
      case (step_x_bits)
         STEP_ZERO: step_x_pos = walker_x_ff;
         STEP_INC:  step_x_pos = walker_x_ff + XW'(1);
         default:   step_x_pos = (walker_x_ff != '0) ? walker_x_ff - XW'(1) : '0;
      endcase
      case (step_y_bits)
         STEP_ZERO: step_y_pos = walker_y_ff;
         STEP_INC:  step_y_pos = walker_y_ff + YW'(1);
         default:   step_y_pos = (walker_y_ff != '0) ? walker_y_ff - YW'(1) : '0;
      endcase
   end

   // neighbourhood addressing around the current walker
   assign xm1    = walker_x_ff - XW'(1);
   assign xp1    = walker_x_ff + XW'(1);
   assign ym1    = walker_y_ff - YW'(1);
   assign yp1    = walker_y_ff + YW'(1);
   assign col_m1 = xm1[COL_AW-1:0];
   assign col_c  = walker_x_ff[COL_AW-1:0];
   assign col_p1 = xp1[COL_AW-1:0];

   always_comb begin
      case (cmd.rd_sel)
         ROW_ABOVE: rd_row = ym1;
         ROW_SAME:  rd_row = walker_y_ff;
         ROW_BELOW: rd_row = yp1;
         default:   rd_row = walker_y_ff;
      endcase
   end

   assign on_edge = (walker_x_ff == '0) || (walker_y_ff == '0) ||
                    (walker_x_ff >= X_MAX) || (walker_y_ff >= Y_MAX);
   assign touch   = (|nb_above_ff) || (|nb_below_ff) ||
                    mid_row_ff[col_m1] || mid_row_ff[col_p1];

   always_comb begin
      if (!placed_ff) begin
         result = ST_IGNORED;
      end else if (on_edge) begin
         result = ST_LOST;
      end else if (touch) begin
         result = ST_STUCK;
      end else begin
         result = ST_WALKING;
      end
   end

   assign stuck = cmd.commit && (result == ST_STUCK);

   // next-state of the walker and the counter
   always_comb begin
      walker_x_in      = walker_x_ff;
      walker_y_in      = walker_y_ff;
      walker_active_in = walker_active_ff;
      placed_in        = placed_ff;
      left_in          = left_ff;
      if (cmd.accept) begin
         placed_in = (left_ff != '0) &&
                     ((op_type'(req_operation) == OP_LAUNCH) || walker_active_ff);
         if (left_ff != '0) begin
            if (op_type'(req_operation) == OP_LAUNCH) begin
               walker_x_in = launch_x;
               walker_y_in = launch_y;
            end else if (walker_active_ff) begin
               walker_x_in = step_x_pos;
               walker_y_in = step_y_pos;
            end
         end
      end
      if (cmd.commit && placed_ff) begin
         walker_active_in = (result == ST_WALKING);
      end
      if (stuck) begin
         left_in = left_ff - COUNT_W'(1);
      end
      if (csr_we) begin
         left_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walker_x_ff      <= '0;
         walker_y_ff      <= '0;
         walker_active_ff <= 1'b0;
         placed_ff        <= 1'b0;
         left_ff          <= COUNT_RESET;
         clr_row_ff       <= '0;
         cap_en_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         walker_x_ff      <= walker_x_in;
         walker_y_ff      <= walker_y_in;
         walker_active_ff <= walker_active_in;
         placed_ff        <= placed_in;
         left_ff          <= left_in;
         cap_en_ff        <= cmd.rd_en;
         if (cmd.clr_en) begin
            clr_row_ff <= clr_row_ff + ROW_AW'(1);
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // captured row data and the result word
   always_ff @(posedge clock) begin
      cap_sel_ff <= cmd.rd_sel;
      if (cap_en_ff) begin
         case (cap_sel_ff)
            ROW_ABOVE: nb_above_ff <= {mem_rdata[col_p1], mem_rdata[col_c], mem_rdata[col_m1]};
            ROW_SAME:  mid_row_ff  <= mem_rdata;
            ROW_BELOW: nb_below_ff <= {mem_rdata[col_p1], mem_rdata[col_c], mem_rdata[col_m1]};
            default:   mid_row_ff  <= mem_rdata;
         endcase
      end
      if (cmd.commit) begin
         rsp_x_ff      <= walker_x_ff[POS_X_W-1:0];
         rsp_y_ff      <= walker_y_ff[POS_Y_W-1:0];
         rsp_status_ff <= result;
         rsp_left_ff   <= left_in;
         rsp_done_ff   <= (left_in == '0);
      end
   end

   // one write port: clear pass, or the set of a stuck particle's cell
   always_comb begin
      mem_we    = cmd.clr_en || stuck;
      mem_waddr = walker_y_ff[ROW_AW-1:0];
      mem_wdata = mid_row_ff | (GRID_WIDTH'(1) << col_c);
      if (cmd.clr_en) begin
         mem_waddr = clr_row_ff;
         mem_wdata = (clr_row_ff == ROW_CENTRE) ? CENTRE_BIT : '0;
      end
   end

   assign mem_re    = cmd.rd_en;
   assign mem_raddr = rd_row[ROW_AW-1:0];

   dpw_grid_mem #(
      .ROW_BITS (GRID_WIDTH),
      .ROWS     (GRID_HEIGHT)
   ) u_grid (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign status.clr_last = (clr_row_ff == ROW_LAST);
   assign status.go_walk  = placed_ff && !on_edge;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = rsp_x_ff;
   assign rsp_pos_y     = rsp_y_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_remaining = rsp_left_ff;
   assign rsp_done      = rsp_done_ff;

   `DPW_ASSERT_NEXT(a_stuck_dec, clock, reset, stuck && !csr_we, left_ff == COUNT_W'($past(left_ff) - 1'b1), "count not decremented")
   `DPW_ASSERT_NEXT(a_lost_idle, clock, reset, cmd.commit && result == ST_LOST, !walker_active_ff, "lost walker still active")
   `DPW_ASSERT_NEXT(a_commit_valid, clock, reset, cmd.commit, rsp_valid_ff, "result word not raised")

endmodule

// ===== design/dla_particle_walk_unit.sv =====
// Particle walk unit: diffusion-limited aggregation on a one-bit occupancy grid.
// Usage: items come in on req_*, one result word per item leaves on rsp_*.
// The particle count register is written on csr_*, which is always ready;
// a write also reloads the remaining count. Write it only while idle.
// After reset the grid goes through a clearing pass over all GRID_HEIGHT
// rows (one row a cycle, centre cell set) with req_tready low; csr writes
// are still taken during that pass.
// An item that is ignored or lost on the edge goes from the decide state
// straight to the finish state. An item at an interior position reads the
// three rows around it from the grid memory, one row a cycle, waits for
// the last row, then commits and writes the stuck cell back. An item is
// accepted only while the unit is idle, so a new item is not taken until
// the last one has committed.
// The result word sits in an output register. When the receiver stalls,
// the next item is still accepted and worked on; its commit waits until the
// held word has been taken. Nothing is dropped.
// Once the remaining count is zero every item answers status ignored.
// Depends on dpw_pkg, dpw_ctrl and dpw_datapath.
module dla_particle_walk_unit #(
   parameter int GRID_WIDTH  = 640,
   parameter int GRID_HEIGHT = 480
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: start_x[9:0], start_y[18:10], step_x[20:19], step_y[22:21], pad
   input  logic [dpw_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: operation (0 launch, 1 move)
   input  logic [dpw_pkg::OP_W-1:0]          req_tuser,
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: pos_x[9:0], pos_y[18:10], remaining[34:19], done_res[35], pad
   output logic [dpw_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // tuser: status (0 walking, 1 stuck, 2 lost, 3 ignored)
   output logic [dpw_pkg::STATUS_W-1:0]      rsp_tuser,
   // particle count register
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dpw_pkg::COUNT_W-1:0]       csr_data
);
   import dpw_pkg::*;

   ctrl_cmd_type                cmd;
   dp_status_type               dp_status;
   logic signed [STEP_W-1:0]    step_x, step_y;
   logic                        rsp_valid;
   logic [POS_X_W-1:0]          pos_x;
   logic [POS_Y_W-1:0]          pos_y;
   status_type                  rsp_status;
   logic [COUNT_W-1:0]          remaining;
   logic                        done_res;

   // unpack the request word
   assign step_x = req_tdata[REQ_STX_LO +: STEP_W];
   assign step_y = req_tdata[REQ_STY_LO +: STEP_W];

   // register port never stalls
   assign csr_ready = 1'b1;

   dpw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (cmd)
   );

   dpw_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (dp_status),
      .req_operation (req_tuser),
      .req_start_x   (req_tdata[REQ_SX_LO +: START_X_W]),
      .req_start_y   (req_tdata[REQ_SY_LO +: START_Y_W]),
      .req_step_x    (step_x),
      .req_step_y    (step_y),
      .csr_we        (csr_valid),
      .csr_data      (csr_data),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_valid),
      .rsp_pos_x     (pos_x),
      .rsp_pos_y     (pos_y),
      .rsp_status    (rsp_status),
      .rsp_remaining (remaining),
      .rsp_done      (done_res)
   );

   // pack the result word
   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, done_res, remaining, pos_y, pos_x};
   assign rsp_tuser  = rsp_status;

endmodule

// ===== bench/dla_particle_walk_unit_tb.sv =====
// Self-checking bench for the particle walk unit: random walks next to the aggregate,
// edge losses, count reloads and output stalls, checked against an in-bench predictor.
// Depends on dpw_pkg and dla_particle_walk_unit.
module dla_particle_walk_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dpw_pkg::*;

   localparam int GRID_W      = 640;
   localparam int GRID_H      = 480;
   localparam int GRID_CELLS  = GRID_W * GRID_H;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   // signed step codes not named in the package
   localparam logic [STEP_W-1:0] STEP_DEC     = 2'b11;   // -1
   localparam logic [STEP_W-1:0] STEP_DEC_SAT = 2'b10;   // -2, saturates to -1

   typedef struct packed {
      logic [POS_X_W-1:0] pos_x;
      logic [POS_Y_W-1:0] pos_y;
      status_type         status;
      logic [COUNT_W-1:0] remaining;
      logic               done;
   } walk_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]        req_tuser  = OP_LAUNCH;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [COUNT_W-1:0]     csr_data   = '0;

   // predictor state
   bit                 occupied [GRID_CELLS];
   int unsigned        cluster_cells [$];
   int                 walker_x;
   int                 walker_y;
   bit                 walker_live;
   logic [COUNT_W-1:0] particles_left;

   walk_result_type walk_results_due [$];
   int              items_sent  = 0;
   int              error_count = 0;
   int              cycle_count = 0;

   // idling controls
   bit gap_on   = 1'b0;
   bit stall_on = 1'b0;
   bit hold_req = 1'b0;
   bit hold_ack = 1'b0;
   int hold_left = 0;

   dla_particle_walk_unit #(
      .GRID_WIDTH  (GRID_W),
      .GRID_HEIGHT (GRID_H)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stalls, or one long hold-off each time hold_req toggles
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_ack   <= hold_req;
      end else begin
         rsp_tready <= !(stall_on && $urandom_range(0, 99) < 20);
      end
   end

   // result checker: every word taken is matched against the oldest prediction
   always @(posedge clock) begin
      walk_result_type got;
      walk_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pos_x     = rsp_tdata[RSP_PX_LO +: POS_X_W];
         got.pos_y     = rsp_tdata[RSP_PY_LO +: POS_Y_W];
         got.status    = status_type'(rsp_tuser);
         got.remaining = rsp_tdata[RSP_REM_LO +: COUNT_W];
         got.done      = rsp_tdata[RSP_DONE_LO];
         if (walk_results_due.size() == 0) begin
            $display("%0t: unexpected word x=%0d y=%0d status=%0d remaining=%0d done=%0d",
                     $time, got.pos_x, got.pos_y, got.status, got.remaining, got.done);
            error_count <= error_count + 1;
         end else begin
            want = walk_results_due.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected x=%0d y=%0d status=%0d remaining=%0d done=%0d",
                        $time, want.pos_x, want.pos_y, want.status, want.remaining, want.done);
               $display("%0t:            actual x=%0d y=%0d status=%0d remaining=%0d done=%0d",
                        $time, got.pos_x, got.pos_y, got.status, got.remaining, got.done);
               error_count <= error_count + 1;
            end
         end
      end
   end

   function automatic int step_coord(int pos, logic [STEP_W-1:0] raw);
      case (raw)
         STEP_ZERO: return pos;
         STEP_INC:  return pos + 1;
         default:   return (pos > 0) ? pos - 1 : 0;   // -1, and -2 saturated
      endcase
   endfunction

   // advances the predictor by one item and returns the word it should produce
   function automatic walk_result_type predict_walk(op_type op, logic [START_X_W-1:0] sx,
                                                    logic [START_Y_W-1:0] sy,
                                                    logic [STEP_W-1:0] stx,
                                                    logic [STEP_W-1:0] sty);
      walk_result_type r;
      bit placed;
      bit hit;
      int idx;
      placed   = 1'b0;
      hit      = 1'b0;
      r.status = ST_IGNORED;
      if (particles_left != 0) begin
         if (op == OP_LAUNCH) begin
            walker_x = (sx > GRID_W - 1) ? GRID_W - 1 : int'(sx);
            walker_y = (sy > GRID_H - 1) ? GRID_H - 1 : int'(sy);
            placed   = 1'b1;
         end else if (walker_live) begin
            walker_x = step_coord(walker_x, stx);
            walker_y = step_coord(walker_y, sty);
            placed   = 1'b1;
         end
         if (placed) begin
            if (walker_x == 0 || walker_y == 0 || walker_x >= GRID_W - 1 ||
                walker_y >= GRID_H - 1) begin
               walker_live = 1'b0;
               r.status    = ST_LOST;
            end else begin
               // eight neighbours, own cell excluded
               for (int dy = -1; dy <= 1; dy++)
                  for (int dx = -1; dx <= 1; dx++)
                     if ((dx != 0 || dy != 0) &&
                         occupied[(walker_y + dy) * GRID_W + walker_x + dx])
                        hit = 1'b1;
               if (hit) begin
                  idx = walker_y * GRID_W + walker_x;
                  if (!occupied[idx])
                     cluster_cells.push_back(idx);
                  occupied[idx]  = 1'b1;
                  particles_left = particles_left - 1'b1;
                  walker_live    = 1'b0;
                  r.status       = ST_STUCK;
               end else begin
                  walker_live = 1'b1;
                  r.status    = ST_WALKING;
               end
            end
         end
      end
      r.pos_x     = POS_X_W'(walker_x);
      r.pos_y     = POS_Y_W'(walker_y);
      r.remaining = particles_left;
      r.done      = (particles_left == 0);
      return r;
   endfunction

   // mostly legal steps, now and then the -2 pattern
   function automatic logic [STEP_W-1:0] random_step();
      case ($urandom_range(0, 9))
         0, 1, 2: return STEP_ZERO;
         3, 4, 5: return STEP_INC;
         6, 7, 8: return STEP_DEC;
         default: return STEP_DEC_SAT;
      endcase
   endfunction

   // one request word; returns at the accepting edge with tvalid still high
   task automatic send_item(op_type op, logic [START_X_W-1:0] sx, logic [START_Y_W-1:0] sy,
                            logic [STEP_W-1:0] stx, logic [STEP_W-1:0] sty);
      logic [REQ_TDATA_W-1:0] word;
      int gap;
      if (gap_on && $urandom_range(0, 99) < 20) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      word = '0;
      word[REQ_SX_LO  +: START_X_W] = sx;
      word[REQ_SY_LO  +: START_Y_W] = sy;
      word[REQ_STX_LO +: STEP_W]    = stx;
      word[REQ_STY_LO +: STEP_W]    = sty;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      walk_results_due.push_back(predict_walk(op, sx, sy, stx, sty));
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (walk_results_due.size() != 0) @(posedge clock);
   endtask

   // reloads particles_left too; only done with nothing in flight
   task automatic write_particle_count(logic [COUNT_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      particles_left = value;
   endtask

   task automatic launch_near_cluster();
      int unsigned c;
      int x;
      int y;
      c = cluster_cells[$urandom_range(0, cluster_cells.size() - 1)];
      x = int'(c % GRID_W) + int'($urandom_range(0, 6)) - 3;
      y = int'(c / GRID_W) + int'($urandom_range(0, 6)) - 3;
      x = (x < 0) ? 0 : (x > GRID_W - 1) ? GRID_W - 1 : x;
      y = (y < 0) ? 0 : (y > GRID_H - 1) ? GRID_H - 1 : y;
      send_item(OP_LAUNCH, START_X_W'(x), START_Y_W'(y), random_step(), random_step());
   endtask

   // launch beside the aggregate and walk until stuck, lost or out of moves
   task automatic walk_particle(int max_moves);
      int n;
      launch_near_cluster();
      n = 0;
      while (walker_live && particles_left != 0 && n < max_moves) begin
         send_item(OP_MOVE, START_X_W'($urandom), START_Y_W'($urandom),
                   random_step(), random_step());
         n++;
      end
   endtask

   task automatic run_walks(int n_items);
      int stop_at;
      int pick;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)
            walk_particle($urandom_range(10, 60));
         else if (pick < 90)   // anywhere, out-of-range corner included
            send_item(OP_LAUNCH, START_X_W'($urandom_range(0, 1023)),
                      START_Y_W'($urandom_range(0, 511)), random_step(), random_step());
         else                  // stray move, often with no walker
            send_item(OP_MOVE, START_X_W'($urandom), START_Y_W'($urandom),
                      random_step(), random_step());
      end
   endtask

   task automatic test_idle_start();
      // reset count visible, no walker yet
      send_item(OP_MOVE, '1, '1, STEP_INC, STEP_INC);
   endtask

   task automatic test_launch_and_edges();
      send_item(OP_LAUNCH, 10'd0,   9'd0,   STEP_ZERO, STEP_ZERO);
      send_item(OP_LAUNCH, 10'd1023, 9'd511, STEP_DEC, STEP_DEC);   // saturates, lost
      send_item(OP_LAUNCH, 10'd639, 9'd200, STEP_ZERO, STEP_ZERO);
      send_item(OP_LAUNCH, 10'd200, 9'd479, STEP_ZERO, STEP_ZERO);
      send_item(OP_LAUNCH, 10'd1,   9'd5,   STEP_ZERO, STEP_ZERO);
      send_item(OP_MOVE,   10'd0,   9'd0,   STEP_DEC, STEP_ZERO);    // walks off the left edge
      send_item(OP_MOVE,   10'd0,   9'd0,   STEP_INC, STEP_INC);     // no walker: ignored
      send_item(OP_LAUNCH, 10'd100, 9'd100, STEP_ZERO, STEP_ZERO);
      send_item(OP_MOVE,   10'd0,   9'd0,   STEP_DEC_SAT, STEP_DEC_SAT);
      send_item(OP_MOVE,   10'd0,   9'd0,   STEP_INC, STEP_DEC);
      send_item(OP_MOVE,   10'd0,   9'd0,   STEP_ZERO, STEP_INC);
   endtask

   task automatic test_sticking();
      send_item(OP_LAUNCH, 10'd320, 9'd240, STEP_ZERO, STEP_ZERO);  // on the seed: walks
      send_item(OP_MOVE,   10'd0,   9'd0,   STEP_INC, STEP_ZERO);   // beside it: sticks
      send_item(OP_LAUNCH, 10'd320, 9'd240, STEP_ZERO, STEP_ZERO);  // set cell set again
      send_item(OP_LAUNCH, 10'd322, 9'd241, STEP_ZERO, STEP_ZERO);  // diagonal contact
   endtask

   task automatic test_particle_count();
      write_particle_count('0);                                      // finished at once
      send_item(OP_LAUNCH, 10'd321, 9'd241, STEP_ZERO, STEP_ZERO);
      send_item(OP_MOVE,   10'd0,   9'd0,   STEP_INC, STEP_INC);
      write_particle_count(16'd1);
      send_item(OP_LAUNCH, 10'd319, 9'd240, STEP_ZERO, STEP_ZERO);  // last one, done
      send_item(OP_LAUNCH, 10'd319, 9'd239, STEP_ZERO, STEP_ZERO);  // ignored
      write_particle_count('1);
      send_item(OP_LAUNCH, 10'd319, 9'd239, STEP_ZERO, STEP_ZERO);
   endtask

   task automatic test_random_walks();
      // steady stretch: no gaps, no stalls
      gap_on   = 1'b0;
      stall_on <= 1'b0;
      run_walks(300);
      gap_on   = 1'b1;
      stall_on <= 1'b1;
      run_walks(400);
      // small count: run out, then see items ignored
      write_particle_count(COUNT_W'($urandom_range(2, 5)));
      run_walks(150);
      write_particle_count(COUNT_RESET);
      run_walks(400);
   endtask

   task automatic test_output_backpressure();
      gap_on   = 1'b0;
      hold_req <= ~hold_req;
      run_walks(15);
      gap_on   = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < GRID_CELLS; i++)
         occupied[i] = 1'b0;
      occupied[(GRID_H / 2) * GRID_W + GRID_W / 2] = 1'b1;
      cluster_cells.push_back((GRID_H / 2) * GRID_W + GRID_W / 2);
      walker_x       = 0;
      walker_y       = 0;
      walker_live    = 1'b0;
      particles_left = COUNT_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // grid clearing pass holds req_tready low; the handshake waits it out
      test_idle_start();
      test_launch_and_edges();
      test_sticking();
      test_particle_count();
      test_random_walks();
      test_output_backpressure();

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/dpw_pkg.sv
design/dpw_grid_mem.sv
design/dpw_ctrl.sv
design/dpw_datapath.sv
design/dla_particle_walk_unit.sv
bench/dla_particle_walk_unit_tb.sv
